>>> hdl/fixed_pattern_noise_calibrate_correct_top_defines.svh
// Assertion macros for the fixed pattern noise block.
// Both expect clk and arst_n in scope.
`ifndef FIXED_PATTERN_NOISE_CALIBRATE_CORRECT_TOP_DEFINES_SVH
`define FIXED_PATTERN_NOISE_CALIBRATE_CORRECT_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FPN_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FPN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/fpn_pkg.sv
`default_nettype none

package fpn_pkg;

	localparam int MaxPixels = 4096;
	localparam int IdxW      = $clog2(MaxPixels);
	localparam int CntW      = IdxW + 1;
	localparam int CfgW      = 13;
	localparam int PixW      = 8;
	localparam int SumW      = 16;
	localparam int FrameW    = 7;
	localparam int AvgShift  = 7;
	localparam int QDepth    = 4;
	localparam int QPtrW     = $clog2(QDepth);

	localparam logic [PixW-1:0] MinInit = 8'd255;

	localparam logic RegCorrEn   = 1'b0;
	localparam logic RegPixCount = 1'b1;

	localparam logic CmdNormal = 1'b0;
	localparam logic CmdCalib  = 1'b1;

	typedef struct packed {
		logic            cal;
		logic            first;
		logic            rebuild;
		logic            last;
		logic [IdxW-1:0] idx;
		logic [PixW-1:0] pix;
	} item_t;

	typedef struct packed {
		logic            corr_en;
		logic [CntW-1:0] n;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic busy;
		logic rebuild_pending;
	} back_stat_t;

	typedef enum logic [2:0] {
		B_RUN,
		B_SCAN,
		B_SCAN_END,
		B_FILL,
		B_FILL_END,
		B_EMIT
	} b_state_t;

endpackage

`default_nettype wire

>>> hdl/fpn_ifs.sv
`default_nettype none

interface fpn_in_if;
	logic                     valid;
	logic                     ready;
	logic                     command;
	logic [fpn_pkg::PixW-1:0] pixel_value;

	modport source (output valid, output command, output pixel_value, input ready);
	modport sink (input valid, input command, input pixel_value, output ready);
endinterface

interface fpn_out_if;
	logic                     valid;
	logic                     ready;
	logic [fpn_pkg::PixW-1:0] pixel_out;
	logic [fpn_pkg::IdxW-1:0] pixel_index;
	logic                     frame_end;
	logic                     calibration_done;

	modport source (output valid, output pixel_out, output pixel_index, output frame_end,
		output calibration_done, input ready);
	modport sink (input valid, input pixel_out, input pixel_index, input frame_end,
		input calibration_done, output ready);
endinterface

interface fpn_cfg_if;
	logic                     valid;
	logic                     ready;
	logic                     index;
	logic [fpn_pkg::CfgW-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/fixed_pattern_noise_calibrate_correct_top.sv
// Fixed pattern noise correction for an 8-bit pixel stream. Each accepted pixel
// is labelled with a frame index that counts down from pixel_count-1 to 0 and
// gives one result. Normal pixels have the stored mask byte subtracted when
// correction is enabled; calibration pixels pass through raw and are summed per
// index, and the end of the 128th calibration frame rebuilds the mask. In
// normal operation one pixel is taken per cycle while the output is ready,
// limited by the single read and write port of the sum store, and passes
// through the queue, the store read and the output register. The rebuild
// makes two passes over the sum store, one entry per cycle, and holds the
// output stream until it ends; the front keeps taking pixels until its
// four-entry queue is full. No clearing pass follows reset. Write the
// configuration registers only while the block is idle.
`default_nettype none
`include "fixed_pattern_noise_calibrate_correct_top_defines.svh"

module fixed_pattern_noise_calibrate_correct_top (
	input logic       clk,
	input logic       arst_n,
	fpn_in_if.sink    pix_in,
	fpn_out_if.source pix_out,
	fpn_cfg_if.sink   cfg
);
	import fpn_pkg::*;

	q_stat_t    q_stat;
	logic       q_push;
	item_t      q_push_item;
	logic       q_pop;
	item_t      q_pop_item;
	cfg_t       cfg_val;
	back_stat_t b_stat;

	fpn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_in    (pix_in),
		.cfg       (cfg),
		.q_stat    (q_stat),
		.push      (q_push),
		.push_item (q_push_item),
		.cfg_val   (cfg_val)
	);

	fpn_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_push_item),
		.pop       (q_pop),
		.pop_item  (q_pop_item),
		.q_stat    (q_stat)
	);

	fpn_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_val  (cfg_val),
		.q_stat   (q_stat),
		.pop_item (q_pop_item),
		.pop      (q_pop),
		.pix_out  (pix_out),
		.b_stat   (b_stat)
	);

	`FPN_ASSERT_NOW(a_done_ends_frame, pix_out.valid && pix_out.calibration_done, pix_out.frame_end && (pix_out.pixel_index == '0), "calibration done off the last pixel")
	`FPN_ASSERT_NOW(a_no_push_full, q_push, !q_stat.full, "request pushed into a full queue")
	`FPN_ASSERT_NOW(a_no_pop_busy, b_stat.busy || b_stat.rebuild_pending, !q_pop, "queue popped during mask rebuild")
	`FPN_ASSERT_NEXT(a_rebuild_starts, b_stat.rebuild_pending && !b_stat.busy, b_stat.busy, "mask rebuild did not start")

endmodule

`default_nettype wire

>>> hdl/fpn_front.sv
`default_nettype none

module fpn_front (
	input  logic             clk,
	input  logic             arst_n,
	fpn_in_if.sink           pix_in,
	fpn_cfg_if.sink          cfg,
	input  fpn_pkg::q_stat_t q_stat,
	output logic             push,
	output fpn_pkg::item_t   push_item,
	output fpn_pkg::cfg_t    cfg_val
);
	import fpn_pkg::*;

	logic              corr_en_q;
	logic [CntW-1:0]   n_q;
	logic [IdxW-1:0]   cnt_q;
	logic [FrameW-1:0] frames_q;
	logic [CntW-1:0]   eff;
	logic              cfg_wr;
	logic              last;

	assign cfg.ready    = 1'b1;
	assign cfg_wr       = cfg.valid && cfg.ready;
	assign pix_in.ready = !q_stat.full;
	assign push         = pix_in.valid && pix_in.ready;

	// clamp the requested pixel count into one to the store depth
	always_comb begin
		if (cfg.data == '0) begin
			eff = CntW'(1);
		end else if (CntW'(cfg.data) > CntW'(MaxPixels)) begin
			eff = CntW'(MaxPixels);
		end else begin
			eff = CntW'(cfg.data);
		end
	end

	assign last = (cnt_q == '0);

	always_comb begin
		push_item.cal     = (pix_in.command == CmdCalib);
		push_item.first   = (frames_q == '0);
		push_item.rebuild = (pix_in.command == CmdCalib) && last && (frames_q == '1);
		push_item.last    = last;
		push_item.idx     = cnt_q;
		push_item.pix     = pix_in.pixel_value;
	end

	assign cfg_val.corr_en = corr_en_q;
	assign cfg_val.n       = n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corr_en_q <= 1'b0;
			n_q       <= CntW'(MaxPixels);
			cnt_q     <= IdxW'(MaxPixels - 1);
			frames_q  <= '0;
		end else if (cfg_wr) begin
			if (cfg.index == RegCorrEn) begin
				corr_en_q <= cfg.data[0];
			end else begin
				// restart the frame, keep calibration progress
				n_q   <= eff;
				cnt_q <= IdxW'(eff - CntW'(1));
			end
		end else if (push) begin
			cnt_q <= last ? IdxW'(n_q - CntW'(1)) : cnt_q - IdxW'(1);
			if (push_item.cal && last) begin
				frames_q <= frames_q + FrameW'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/fpn_queue.sv
`default_nettype none

module fpn_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  fpn_pkg::item_t   push_item,
	input  logic             pop,
	output fpn_pkg::item_t   pop_item,
	output fpn_pkg::q_stat_t q_stat
);
	import fpn_pkg::*;

	item_t             slots [QDepth];
	logic [QPtrW-1:0]  wr_ptr_q;
	logic [QPtrW-1:0]  rd_ptr_q;
	logic [QPtrW:0]    count_q;

	assign q_stat.full  = (count_q == (QPtrW + 1)'(QDepth));
	assign q_stat.empty = (count_q == '0);
	assign pop_item     = slots[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPtrW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (QPtrW + 1)'(1);
				2'b01:   count_q <= count_q - (QPtrW + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hdl/fpn_back.sv
`default_nettype none

module fpn_back (
	input  logic                clk,
	input  logic                arst_n,
	input  fpn_pkg::cfg_t       cfg_val,
	input  fpn_pkg::q_stat_t    q_stat,
	input  fpn_pkg::item_t      pop_item,
	output logic                pop,
	fpn_out_if.source           pix_out,
	output fpn_pkg::back_stat_t b_stat
);
	import fpn_pkg::*;

	logic [SumW-1:0] sum_mem  [MaxPixels];
	logic [PixW-1:0] mask_mem [MaxPixels];

	b_state_t        state_q, state_d;

	logic [SumW-1:0] sum_rd_q;
	logic [PixW-1:0] mask_rd_q;

	logic            s1_valid_q;
	item_t           item_s1;
	logic            fwd_hit_s1;
	logic [SumW-1:0] fwd_data_s1;
	logic            mask_ok_s1;

	logic            out_valid_q;
	logic [PixW-1:0] out_pix_q;
	logic [IdxW-1:0] out_idx_q;
	logic            out_end_q;
	logic            out_done_q;

	logic [IdxW-1:0] scan_cnt_q;
	logic            rv_q;
	logic [IdxW-1:0] rv_idx_q;
	logic [PixW-1:0] min_q;
	logic [CntW-1:0] fill_q;
	logic [PixW-1:0] pend_pix_q;

	logic            out_free;
	logic            s1_adv;
	logic            start_rebuild;
	logic            s1_emit;
	logic            sum_we;
	logic [SumW-1:0] sum_old;
	logic [SumW-1:0] sum_new;
	logic [PixW-1:0] mask_sub;
	logic [PixW-1:0] res;
	logic [PixW-1:0] avg;
	logic [IdxW-1:0] last_idx;
	logic            scan_rd;
	logic            scan_ph;
	logic            fill_ph;
	logic            emit;
	logic            sum_re;
	logic [IdxW-1:0] sum_ra;
	logic            mask_we;

	assign out_free      = !out_valid_q || pix_out.ready;
	assign s1_adv        = s1_valid_q && (item_s1.rebuild || out_free);
	assign start_rebuild = s1_adv && item_s1.rebuild;
	assign s1_emit       = s1_adv && !item_s1.rebuild;
	assign sum_we        = s1_adv && item_s1.cal;
	assign last_idx      = IdxW'(cfg_val.n - CntW'(1));

	// the previous write may have landed on the same edge as this read
	assign sum_old = fwd_hit_s1 ? fwd_data_s1 : sum_rd_q;
	assign sum_new = item_s1.first ? SumW'(item_s1.pix) : sum_old + SumW'(item_s1.pix);

	assign mask_sub = mask_ok_s1 ? mask_rd_q : '0;
	assign res      = (item_s1.cal || !cfg_val.corr_en) ? item_s1.pix : item_s1.pix - mask_sub;
	assign avg      = sum_rd_q[AvgShift +: PixW];

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_RUN: begin
				if (start_rebuild) begin
					state_d = B_SCAN;
				end
			end
			B_SCAN: begin
				if (scan_cnt_q == last_idx) begin
					state_d = B_SCAN_END;
				end
			end
			B_SCAN_END: state_d = B_FILL;
			B_FILL: begin
				if (scan_cnt_q == last_idx) begin
					state_d = B_FILL_END;
				end
			end
			B_FILL_END: state_d = B_EMIT;
			B_EMIT: begin
				if (out_free) begin
					state_d = B_RUN;
				end
			end
			default: state_d = B_RUN;
		endcase
	end

	always_comb begin
		pop     = 1'b0;
		scan_rd = 1'b0;
		scan_ph = 1'b0;
		fill_ph = 1'b0;
		emit    = 1'b0;
		case (state_q)
			B_RUN: begin
				pop = !q_stat.empty && (!s1_valid_q || s1_emit);
			end
			B_SCAN: begin
				scan_rd = 1'b1;
				scan_ph = 1'b1;
			end
			B_SCAN_END: scan_ph = 1'b1;
			B_FILL: begin
				scan_rd = 1'b1;
				fill_ph = 1'b1;
			end
			B_FILL_END: fill_ph = 1'b1;
			B_EMIT: emit = out_free;
			default: pop = 1'b0;
		endcase
	end

	assign sum_re  = pop || scan_rd;
	assign sum_ra  = pop ? pop_item.idx : scan_cnt_q;
	assign mask_we = rv_q && fill_ph;

	always_ff @(posedge clk) begin
		if (sum_we) begin
			sum_mem[item_s1.idx] <= sum_new;
		end
		if (sum_re) begin
			sum_rd_q <= sum_mem[sum_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (mask_we) begin
			mask_mem[rv_idx_q] <= avg - min_q;
		end
		if (pop) begin
			mask_rd_q <= mask_mem[pop_item.idx];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1     <= pop_item;
			fwd_hit_s1  <= sum_we && (item_s1.idx == pop_item.idx);
			fwd_data_s1 <= sum_new;
			// entries beyond the rebuilt range were never written and count as zero
			mask_ok_s1  <= ({1'b0, pop_item.idx} < fill_q);
		end
		if (start_rebuild) begin
			pend_pix_q <= item_s1.pix;
		end
		if (emit) begin
			out_pix_q  <= pend_pix_q;
			out_idx_q  <= '0;
			out_end_q  <= 1'b1;
			out_done_q <= 1'b1;
		end else if (s1_emit) begin
			out_pix_q  <= res;
			out_idx_q  <= item_s1.idx;
			out_end_q  <= item_s1.last;
			out_done_q <= 1'b0;
		end
		rv_idx_q <= scan_cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_RUN;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			scan_cnt_q  <= '0;
			rv_q        <= 1'b0;
			min_q       <= MinInit;
			fill_q      <= '0;
		end else begin
			state_q <= state_d;
			rv_q    <= scan_rd;
			if (pop) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (emit || s1_emit) begin
				out_valid_q <= 1'b1;
			end else if (pix_out.ready) begin
				out_valid_q <= 1'b0;
			end
			if (start_rebuild) begin
				scan_cnt_q <= '0;
				min_q      <= MinInit;
			end else if (scan_rd) begin
				scan_cnt_q <= (scan_cnt_q == last_idx) ? '0 : scan_cnt_q + IdxW'(1);
			end
			if (rv_q && scan_ph && (avg != '0) && (avg < min_q)) begin
				min_q <= avg;
			end
			if ((state_q == B_FILL_END) && (cfg_val.n > fill_q)) begin
				fill_q <= cfg_val.n;
			end
		end
	end

	assign pix_out.valid            = out_valid_q;
	assign pix_out.pixel_out        = out_pix_q;
	assign pix_out.pixel_index      = out_idx_q;
	assign pix_out.frame_end        = out_end_q;
	assign pix_out.calibration_done = out_done_q;

	assign b_stat.busy            = (state_q != B_RUN);
	assign b_stat.rebuild_pending = s1_valid_q && item_s1.rebuild;

endmodule

`default_nettype wire

>>> verif/fpn_correction_checker.sv
module fpn_correction_checker (
	input  logic clk,
	input  logic arst_n,
	fpn_in_if    pix_in,
	fpn_out_if   pix_out,
	fpn_cfg_if   cfg,
	output int   fail_count,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import fpn_pkg::*;

	typedef struct packed {
		logic [PixW-1:0] pix;
		logic [IdxW-1:0] idx;
		logic            frame_end;
		logic            done;
	} pixel_result_t;

	logic [SumW-1:0]   sum_mem  [MaxPixels];
	logic [PixW-1:0]   mask_mem [MaxPixels];
	logic [IdxW-1:0]   index_ctr;
	logic [FrameW-1:0] cal_frames;
	logic [PixW-1:0]   min_avg;
	logic              corr_en;
	logic [CfgW-1:0]   pix_count;
	pixel_result_t     out_pixel_q [$];
	int                errs;

	function automatic int frame_len(logic [CfgW-1:0] c);
		if (c == '0)
			return 1;
		if (int'(c) > MaxPixels)
			return MaxPixels;
		return int'(c);
	endfunction

	// average is bits 14:7 of the sum, i.e. the shifted sum cut to 8 bits
	task automatic rebuild_mask();
		int              n;
		logic [PixW-1:0] lowest;
		logic [PixW-1:0] avg;
		n = frame_len(pix_count);
		lowest = MinInit;
		for (int k = 0; k < n; k++) begin
			avg = sum_mem[k][AvgShift +: PixW];
			if (avg != '0 && avg < lowest)
				lowest = avg;
		end
		min_avg = lowest;
		for (int k = 0; k < n; k++) begin
			avg = sum_mem[k][AvgShift +: PixW];
			mask_mem[k] = avg - lowest;
		end
	endtask

	task automatic correct_pixel(input logic cmd, input logic [PixW-1:0] pix,
		output pixel_result_t res);
		int              n;
		logic [IdxW-1:0] idx;
		logic            last;
		n = frame_len(pix_count);
		if (int'(index_ctr) >= n)
			index_ctr = IdxW'(n - 1);
		idx = index_ctr;
		last = (idx == '0);
		res.pix = pix;
		res.idx = idx;
		res.frame_end = last;
		res.done = 1'b0;
		if (cmd == CmdCalib) begin
			if (cal_frames == '0)
				sum_mem[idx] = SumW'(pix);
			else
				sum_mem[idx] = sum_mem[idx] + SumW'(pix);
			if (last) begin
				cal_frames = cal_frames + 1'b1;
				if (cal_frames == '0) begin
					rebuild_mask();
					res.done = 1'b1;
				end
			end
		end else if (corr_en) begin
			res.pix = pix - mask_mem[idx];
		end
		index_ctr = last ? IdxW'(n - 1) : idx - 1'b1;
	endtask

	always @(posedge clk) begin
		pixel_result_t want;
		pixel_result_t fresh;
		if (!arst_n) begin
			for (int k = 0; k < MaxPixels; k++) begin
				sum_mem[k] = '0;
				mask_mem[k] = '0;
			end
			corr_en = 1'b0;
			pix_count = CfgW'(MaxPixels);
			index_ctr = IdxW'(MaxPixels - 1);
			cal_frames = '0;
			min_avg = MinInit;
			out_pixel_q.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == RegCorrEn) begin
					corr_en = cfg.data[0];
				end else begin
					pix_count = cfg.data;
					index_ctr = IdxW'(frame_len(cfg.data) - 1);
				end
			end
			// results leave before this edge's request can reach the output
			if (pix_out.valid && pix_out.ready) begin
				if (out_pixel_q.size() == 0) begin
					errs++;
					$error("unrequested result: pixel_index %0d pixel_out %0d",
						pix_out.pixel_index, pix_out.pixel_out);
				end else begin
					want = out_pixel_q.pop_front();
					if (pix_out.pixel_out !== want.pix) begin
						errs++;
						$error("pixel_out: expected %0d, got %0d", want.pix, pix_out.pixel_out);
					end
					if (pix_out.pixel_index !== want.idx) begin
						errs++;
						$error("pixel_index: expected %0d, got %0d", want.idx,
							pix_out.pixel_index);
					end
					if (pix_out.frame_end !== want.frame_end) begin
						errs++;
						$error("frame_end: expected %0d, got %0d", want.frame_end,
							pix_out.frame_end);
					end
					if (pix_out.calibration_done !== want.done) begin
						errs++;
						$error("calibration_done: expected %0d, got %0d", want.done,
							pix_out.calibration_done);
					end
				end
			end
			if (pix_in.valid && pix_in.ready) begin
				correct_pixel(pix_in.command, pix_in.pixel_value, fresh);
				out_pixel_q.push_back(fresh);
			end
		end
		fail_count <= errs;
		outstanding <= out_pixel_q.size();
	end

endmodule

>>> verif/tb_fixed_pattern_noise_calibrate_correct_top.sv
module tb_fixed_pattern_noise_calibrate_correct_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fpn_pkg::*;

	localparam int StallLimit = 20000;
	localparam int RandomItems = 24;
	localparam int CalWidth = 8;

	logic clk;
	logic arst_n;

	fpn_in_if  pix_in ();
	fpn_out_if pix_out ();
	fpn_cfg_if cfg ();

	int fail_count;
	int outstanding;
	int idle_cycles;
	int items_sent;
	bit idle_on = 1'b1;

	// sender-side view of the frame position, to keep sum reads on written entries
	int trk_len;
	int trk_ctr;
	int trk_frames;
	bit sum_seen [MaxPixels];

	fixed_pattern_noise_calibrate_correct_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in),
		.pix_out (pix_out),
		.cfg     (cfg)
	);

	fpn_correction_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.pix_in      (pix_in),
		.pix_out     (pix_out),
		.cfg         (cfg),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		pix_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				pix_out.ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			pix_out.ready <= 1'b1;
			repeat ($urandom_range(0, 15)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)
			|| (cfg.valid && cfg.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= StallLimit) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic int eff_len(int c);
		if (c == 0)
			return 1;
		if (c > MaxPixels)
			return MaxPixels;
		return c;
	endfunction

	// a calibration pixel may read its sum only once that entry has been written
	function automatic bit cal_ok();
		if (trk_frames == 0)
			return 1'b1;
		if (!sum_seen[trk_ctr])
			return 1'b0;
		if (trk_ctr == 0 && trk_frames == 127) begin
			for (int k = 0; k < trk_len; k++)
				if (!sum_seen[k])
					return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic wait_drained();
		pix_in.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_reg(input logic idx, input logic [CfgW-1:0] val);
		wait_drained();
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		if (idx == RegPixCount) begin
			trk_len = eff_len(int'(val));
			trk_ctr = trk_len - 1;
		end
	endtask

	task automatic send(input logic cmd, input logic [PixW-1:0] val);
		logic c;
		c = cmd;
		if (c == CmdCalib && !cal_ok())
			c = CmdNormal;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			pix_in.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		pix_in.valid <= 1'b1;
		pix_in.command <= c;
		pix_in.pixel_value <= val;
		// hold the request until accepted
		@(posedge clk);
		while (!pix_in.ready) @(posedge clk);
		items_sent++;
		if (c == CmdCalib) begin
			sum_seen[trk_ctr] = 1'b1;
			if (trk_ctr == 0)
				trk_frames = (trk_frames + 1) % 128;
		end
		trk_ctr = (trk_ctr == 0) ? trk_len - 1 : trk_ctr - 1;
	endtask

	task automatic set_enable(input logic en);
		write_reg(RegCorrEn, {(CfgW - 1)'($urandom_range(0, 4095)), en});
	endtask

	task automatic run_frames();
		int              sel;
		logic [CfgW-1:0] len;
		sel = $urandom_range(0, 19);
		if (sel == 0)
			len = '0;
		else if (sel == 1)
			len = CfgW'(MaxPixels);
		else if (sel == 2)
			len = '1;
		else if (sel == 3)
			len = CfgW'($urandom_range(0, 8191));
		else
			len = CfgW'($urandom_range(1, 8));
		write_reg(RegPixCount, len);
		set_enable(1'($urandom_range(0, 1)));
		repeat ($urandom_range(8, 40))
			send(($urandom_range(0, 9) == 0) ? CmdCalib : CmdNormal,
				PixW'($urandom_range(0, 255)));
	endtask

	initial begin
		logic [PixW-1:0] first_vals [CalWidth];
		int              random_start;
		first_vals = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd127, 8'd254, 8'h55, 8'haa};
		arst_n <= 1'b0;
		pix_in.valid <= 1'b0;
		pix_in.command <= CmdNormal;
		pix_in.pixel_value <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= RegCorrEn;
		cfg.data <= '0;
		trk_len = MaxPixels;
		trk_ctr = MaxPixels - 1;
		trk_frames = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// first calibration frame writes every sum entry that later frames use
		write_reg(RegPixCount, CfgW'(CalWidth));
		set_enable(1'b1);
		for (int k = 0; k < CalWidth; k++)
			send(CmdCalib, first_vals[k]);
		send(CmdNormal, 8'd0);
		send(CmdNormal, 8'd255);
		// zero count behaves as one pixel per frame
		write_reg(RegPixCount, '0);
		repeat (3) send(CmdNormal, PixW'($urandom_range(0, 255)));
		send(CmdCalib, 8'd200);
		// oversized count clamps to the full array
		write_reg(RegPixCount, '1);
		send(CmdNormal, 8'd17);
		send(CmdNormal, 8'd255);
		write_reg(RegPixCount, CfgW'(MaxPixels));
		send(CmdNormal, 8'd0);
		write_reg(RegPixCount, 13'd1);
		send(CmdCalib, 8'd99);
		set_enable(1'b0);
		send(CmdNormal, 8'd3);
		// mixed commands inside one frame
		write_reg(RegPixCount, 13'd3);
		send(CmdNormal, 8'd10);
		send(CmdCalib, 8'd20);
		send(CmdNormal, 8'd30);
		send(CmdCalib, 8'd40);

		// drive one sum past 16 bits by restarting the frame before it ends
		repeat (260) begin
			write_reg(RegPixCount, 13'd2);
			send(CmdCalib, 8'd255);
		end
		write_reg(RegPixCount, 13'd1);
		while (trk_frames != 127)
			send(CmdCalib, PixW'($urandom_range(0, 255)));
		write_reg(RegPixCount, 13'd2);
		send(CmdCalib, 8'd255);
		send(CmdCalib, PixW'($urandom_range(0, 255)));
		set_enable(1'b1);
		repeat (6) send(CmdNormal, PixW'($urandom_range(0, 255)));

		random_start = items_sent;
		while (items_sent - random_start < RandomItems) begin
			idle_on = ($urandom_range(0, 5) != 0);
			run_frames();
		end
		// finish with one stretch of unbroken traffic
		idle_on = 1'b0;
		run_frames();

		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
